// ===== rtl/cvh_pkg.sv =====
// cvh_pkg: shared constants, types and helpers for the chroma vectorscope histogram
// depends on nothing; used by scoped names in chroma_vectorscope_histogram_top, histogram_checker and testbench
package cvh_pkg;

  // axis geometry of the bin store
  localparam int AXIS_BITS = 8;
  localparam int ADDR_W    = 2 * AXIS_BITS;
  localparam int DEPTH     = 1 << ADDR_W;

  typedef logic [AXIS_BITS-1:0] axis_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [7:0]           bin_t;

  // request kinds
  typedef enum logic {
    REQ_ACCUM = 1'b0,
    REQ_READ  = 1'b1
  } req_t;

  localparam bin_t STEP_RESET = 8'h0f;
  localparam bin_t BIN_FULL   = 8'hff;
  localparam addr_t ADDR_LAST = '1;

  // bin address: row in the upper half, column in the lower half
  function automatic addr_t bin_addr(input axis_t col, input axis_t row);
    bin_addr = {row, col};
  endfunction

  // saturating add of the step to a bin byte
  function automatic bin_t sat_add(input bin_t old_val, input bin_t step);
    logic [8:0] sum;
    sum = {1'b0, old_val} + {1'b0, step};
    sat_add = sum[8] ? BIN_FULL : sum[7:0];
  endfunction

endpackage

// ===== rtl/chroma_vectorscope_histogram_top.sv =====
// chroma_vectorscope_histogram_top: 2d chroma histogram in one synchronous bin memory
// depends on cvh_pkg (geometry, request codes, saturating add)
//
// usage
//   input channel (in_valid / in_stall): one request per transfer. in_req_type
//   REQ_ACCUM bumps the bin at column U, row (axis max - V) by the step, saturating
//   at 255; REQ_READ returns the byte at column U, row V and clears that bin.
//   result channel (out_valid / out_stall): one out_bin_value per read request,
//   in request order; accumulate requests give no result.
//   config channel (cfg_valid / cfg_ready): writes the increment step, always ready.
//   throughput: one request per cycle while in_stall is low, set by the single
//   read-modify-write pass through the bin memory (read at accept, write back in the
//   following cycle, with forwarding between neighboring requests to the same bin).
//   a read result passes the s1 stage and then the output queue before it can transfer.
//   stall: results collect in a three-entry output queue; in_stall rises when the
//   queue plus the read in flight reach three, so nothing is dropped.
//   reset: synchronous, active low. the step returns to 15 and a clearing pass
//   zeroes all 65536 bins, one per cycle; in_stall stays high throughout the pass,
//   and config writes are taken all along.
module chroma_vectorscope_histogram_top (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_req_type,
  input  logic [7:0]          in_chroma_u,
  input  logic [7:0]          in_chroma_v,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_bin_value,
  // config channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_increment_step
);

  // bin memory
  cvh_pkg::bin_t mem [cvh_pkg::DEPTH];

  // control and datapath registers
  logic           clr_active_r;
  cvh_pkg::addr_t clr_addr_r;
  cvh_pkg::bin_t  step_r;

  logic           s1_valid_r;
  logic           s1_read_r;
  cvh_pkg::addr_t s1_addr_r;
  cvh_pkg::bin_t  rd_data_r;

  logic           wb_valid_r;
  cvh_pkg::addr_t wb_addr_r;
  cvh_pkg::bin_t  wb_data_r;

  logic [1:0]     q_cnt_r, q_cnt_nxt;
  cvh_pkg::bin_t  q0_r, q0_nxt;
  cvh_pkg::bin_t  q1_r, q1_nxt;
  cvh_pkg::bin_t  q2_r, q2_nxt;

  logic           in_xfer;
  logic           out_pop;
  logic           q_push;
  cvh_pkg::axis_t in_col;
  cvh_pkg::axis_t in_row;
  cvh_pkg::addr_t in_addr;
  cvh_pkg::bin_t  s1_old;
  cvh_pkg::bin_t  s1_new;
  logic           mem_we;
  cvh_pkg::addr_t mem_wa;
  cvh_pkg::bin_t  mem_wd;

  // handshakes
  assign cfg_ready = 1'b1;
  assign in_stall  = clr_active_r
                   | ((3'(q_cnt_r) + 3'(s1_valid_r & s1_read_r)) >= 3'd3);
  assign in_xfer   = in_valid & ~in_stall;
  assign out_valid = (q_cnt_r != 2'd0);
  assign out_bin_value = q0_r;
  assign out_pop   = out_valid & ~out_stall;

  // bin address of the incoming request
  assign in_col  = cvh_pkg::axis_t'(in_chroma_u);
  assign in_row  = (in_req_type == cvh_pkg::REQ_READ) ? cvh_pkg::axis_t'(in_chroma_v)
                                                      : ~cvh_pkg::axis_t'(in_chroma_v);
  assign in_addr = cvh_pkg::bin_addr(in_col, in_row);

  // old bin value, forwarded from the write back of the previous request
  assign s1_old = (wb_valid_r && (wb_addr_r == s1_addr_r)) ? wb_data_r : rd_data_r;
  assign s1_new = s1_read_r ? 8'h00 : cvh_pkg::sat_add(s1_old, step_r);
  assign q_push = s1_valid_r & s1_read_r;

  // memory write port: clearing pass or write back
  always_comb begin
    if (clr_active_r) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_r;
      mem_wd = 8'h00;
    end else begin
      mem_we = s1_valid_r;
      mem_wa = s1_addr_r;
      mem_wd = s1_new;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (in_xfer) begin
      rd_data_r <= mem[in_addr];
    end
  end

  // output queue next state
  always_comb begin
    q0_nxt    = q0_r;
    q1_nxt    = q1_r;
    q2_nxt    = q2_r;
    q_cnt_nxt = q_cnt_r;
    if (out_pop) begin
      q0_nxt    = q1_r;
      q1_nxt    = q2_r;
      q_cnt_nxt = q_cnt_r - 2'd1;
    end
    if (q_push) begin
      case (q_cnt_nxt)
        2'd0: begin
          q0_nxt = s1_old;
        end
        2'd1: begin
          q1_nxt = s1_old;
        end
        default: begin
          q2_nxt = s1_old;
        end
      endcase
      q_cnt_nxt = q_cnt_nxt + 2'd1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      step_r       <= cvh_pkg::STEP_RESET;
      s1_valid_r   <= 1'b0;
      wb_valid_r   <= 1'b0;
      q_cnt_r      <= 2'd0;
    end else begin
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + cvh_pkg::addr_t'(1);
        if (clr_addr_r == cvh_pkg::ADDR_LAST) begin
          clr_active_r <= 1'b0;
        end
      end
      if (cfg_valid && cfg_ready) begin
        step_r <= cfg_increment_step;
      end
      s1_valid_r <= in_xfer;
      wb_valid_r <= s1_valid_r;
      q_cnt_r    <= q_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_read_r <= (in_req_type == cvh_pkg::REQ_READ);
      s1_addr_r <= in_addr;
    end
    wb_addr_r <= s1_addr_r;
    wb_data_r <= s1_new;
    q0_r      <= q0_nxt;
    q1_r      <= q1_nxt;
    q2_r      <= q2_nxt;
  end

  // a stalled result holds its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bin_value))
    else $error("stalled result changed");

  // a read result always finds a free queue slot
  assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_cnt_r < 2'd3) || out_pop)
    else $error("read result pushed into full queue");

  // clearing pass ends only after the last bin
  assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_active_r) |-> $past(clr_addr_r) == cvh_pkg::ADDR_LAST)
    else $error("clearing pass ended early");

  // no request reaches the memory while clearing
  assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !s1_valid_r)
    else $error("request in flight during clearing pass");

endmodule

// ===== tb/histogram_checker.sv =====
`timescale 1ns / 100ps
// histogram_checker: keeps a shadow copy of the bin store and step, scores every read result
// depends on cvh_pkg for the axis geometry, request codes and the step reset value
module histogram_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_req_type,
  input  logic [7:0] in_chroma_u,
  input  logic [7:0] in_chroma_v,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_bin_value,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_increment_step,
  output int         mismatches,
  output int         reads_due
);

  localparam cvh_pkg::axis_t AXIS_MAX = '1;

  cvh_pkg::bin_t bin_image [cvh_pkg::DEPTH];
  cvh_pkg::bin_t step_now;
  cvh_pkg::bin_t read_values_due [$];

  // watch all three channels at each edge
  always @(posedge clk) begin
    cvh_pkg::axis_t col;
    cvh_pkg::axis_t row;
    cvh_pkg::addr_t slot;
    cvh_pkg::bin_t  want;
    logic [8:0]     sum;
    if (!rst_n) begin
      step_now = cvh_pkg::STEP_RESET;
      foreach (bin_image[i]) bin_image[i] = '0;
      read_values_due.delete();
      mismatches = 0;
    end else begin
      // result transfer scored against the oldest pending read
      if (out_valid && !out_stall) begin
        if (read_values_due.size() == 0) begin
          $error("bin_value: expected none, actual %0d", out_bin_value);
          mismatches++;
        end else begin
          want = read_values_due.pop_front();
          if (out_bin_value !== want) begin
            $error("bin_value: expected %0d, actual %0d", want, out_bin_value);
            mismatches++;
          end
        end
      end
      // step register write
      if (cfg_valid && cfg_ready) step_now = cfg_increment_step;
      // request transfer
      if (in_valid && !in_stall) begin
        col = cvh_pkg::axis_t'(in_chroma_u);
        if (in_req_type == cvh_pkg::REQ_ACCUM) begin
          // row counts down from the top of the picture
          row  = AXIS_MAX - cvh_pkg::axis_t'(in_chroma_v);
          slot = {row, col};
          if (bin_image[slot] != cvh_pkg::BIN_FULL) begin
            sum = {1'b0, bin_image[slot]} + {1'b0, step_now};
            bin_image[slot] = (sum > {1'b0, cvh_pkg::BIN_FULL}) ? cvh_pkg::BIN_FULL
                                                                : sum[7:0];
          end
        end else begin
          // read returns the byte, then clears the bin
          row  = cvh_pkg::axis_t'(in_chroma_v);
          slot = {row, col};
          read_values_due.push_back(bin_image[slot]);
          bin_image[slot] = '0;
        end
      end
    end
    reads_due = read_values_due.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// testbench: clock, reset, request and step stimulus, result stalls and the verdict
// depends on cvh_pkg, chroma_vectorscope_histogram_top and histogram_checker
module testbench;

  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT   = 300000;
  localparam int PHASE_ITEMS   = 80;
  localparam int PHASE_COUNT   = 5;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_req_type;
  logic [7:0] in_chroma_u;
  logic [7:0] in_chroma_v;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_bin_value;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_increment_step;

  int mismatches;
  int reads_due;
  int idle_cycles = 0;
  int stall_left  = 0;
  int free_left   = 8;
  bit calm        = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  chroma_vectorscope_histogram_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_chroma_u        (in_chroma_u),
    .in_chroma_v        (in_chroma_v),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_bin_value      (out_bin_value),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_increment_step (cfg_increment_step)
  );

  histogram_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_chroma_u        (in_chroma_u),
    .in_chroma_v        (in_chroma_v),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_bin_value      (out_bin_value),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_increment_step (cfg_increment_step),
    .mismatches         (mismatches),
    .reads_due          (reads_due)
  );

  // result side stalls in bursts, quiet stretches in between
  always @(posedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (out_stall) begin
      if (stall_left <= 1) begin
        out_stall <= 1'b0;
        free_left <= $urandom_range(1, 40);
      end else begin
        stall_left <= stall_left - 1;
      end
    end else if (free_left <= 1) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 18);
    end else begin
      free_left <= free_left - 1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one request transfer, optionally after a gap
  task automatic send_req(input cvh_pkg::req_t kind, input logic [7:0] u,
                          input logic [7:0] v);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_chroma_u <= u;
    in_chroma_v <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off requests until every read result is back and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (reads_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_step(input cvh_pkg::bin_t step);
    cfg_valid          <= 1'b1;
    cfg_increment_step <= step;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly a few hot bins that fill up and get read back, some scattered traffic
  task automatic run_mixed_phase(input int count);
    logic [7:0] hot_u [4];
    logic [7:0] hot_v [4];
    int         pick;
    int         k;
    foreach (hot_u[i]) begin
      hot_u[i] = 8'($urandom_range(0, 255));
      hot_v[i] = 8'($urandom_range(0, 255));
    end
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, 3);
      if (pick < 55) begin
        send_req(cvh_pkg::REQ_ACCUM, hot_u[k], hot_v[k]);
      end else if (pick < 80) begin
        // accumulate row of a hot bin is the inverted v
        send_req(cvh_pkg::REQ_READ, hot_u[k], ~hot_v[k]);
      end else if (pick < 92) begin
        send_req(cvh_pkg::REQ_ACCUM, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
      end else begin
        send_req(cvh_pkg::REQ_READ, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    cvh_pkg::bin_t phase_step;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_req_type        = cvh_pkg::REQ_ACCUM;
    in_chroma_u        = '0;
    in_chroma_v        = '0;
    cfg_valid          = 1'b0;
    cfg_increment_step = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset step: picture corners and a mid bin, then read back, re-read a cleared bin
    send_req(cvh_pkg::REQ_ACCUM, 8'h00, 8'h00);
    send_req(cvh_pkg::REQ_ACCUM, 8'hff, 8'hff);
    send_req(cvh_pkg::REQ_ACCUM, 8'h00, 8'hff);
    send_req(cvh_pkg::REQ_ACCUM, 8'hff, 8'h00);
    send_req(cvh_pkg::REQ_ACCUM, 8'h55, 8'haa);
    send_req(cvh_pkg::REQ_READ,  8'h00, 8'hff);
    send_req(cvh_pkg::REQ_READ,  8'hff, 8'h00);
    send_req(cvh_pkg::REQ_READ,  8'h00, 8'h00);
    send_req(cvh_pkg::REQ_READ,  8'hff, 8'hff);
    send_req(cvh_pkg::REQ_READ,  8'h55, 8'h55);
    send_req(cvh_pkg::REQ_READ,  8'h55, 8'h55);
    send_req(cvh_pkg::REQ_READ,  8'haa, 8'haa);
    settle();

    // largest step: bin saturates and stays full
    write_step(cvh_pkg::BIN_FULL);
    send_req(cvh_pkg::REQ_ACCUM, 8'h12, 8'h34);
    send_req(cvh_pkg::REQ_ACCUM, 8'h12, 8'h34);
    send_req(cvh_pkg::REQ_ACCUM, 8'h12, 8'h34);
    send_req(cvh_pkg::REQ_READ,  8'h12, 8'hcb);
    settle();

    // zero step leaves the bin untouched
    write_step(8'd0);
    send_req(cvh_pkg::REQ_ACCUM, 8'h01, 8'h01);
    send_req(cvh_pkg::REQ_READ,  8'h01, 8'hfe);
    settle();

    // smallest nonzero step
    write_step(8'd1);
    send_req(cvh_pkg::REQ_ACCUM, 8'h07, 8'h07);
    send_req(cvh_pkg::REQ_ACCUM, 8'h07, 8'h07);
    send_req(cvh_pkg::REQ_READ,  8'h07, 8'hf8);
    settle();

    // random phases, each under its own step; the last one runs without idling
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        1:       phase_step = cvh_pkg::BIN_FULL;
        2:       phase_step = 8'd1;
        default: phase_step = 8'($urandom_range(2, 254));
      endcase
      if (p == PHASE_COUNT - 1) calm = 1'b1;
      write_step(phase_step);
      run_mixed_phase(PHASE_ITEMS);
      settle();
    end

    @(negedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cvh_pkg.sv
rtl/chroma_vectorscope_histogram_top.sv
tb/histogram_checker.sv
tb/testbench.sv
